@@ hw/rtl/ihex_pkg.sv @@
// Shared types, codes and the hex digit decoder for the Intel HEX record parser.
// No dependencies; the files that use it refer to this package by scoped names.
package ihex_pkg;

	// Result kinds
	localparam logic [2:0] KIND_DATA = 3'd0;
	localparam logic [2:0] KIND_OK   = 3'd1;
	localparam logic [2:0] KIND_EOF  = 3'd2;
	localparam logic [2:0] KIND_CSUM = 3'd3;
	localparam logic [2:0] KIND_BAD  = 3'd4;

	// Characters with a meaning of their own
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_LF    = 8'h0A;

	// Record types
	localparam logic [7:0] REC_DATA    = 8'h00;
	localparam logic [7:0] REC_EOF     = 8'h01;
	localparam logic [7:0] REC_EXT_SEG = 8'h02;
	localparam logic [7:0] REC_EXT_LIN = 8'h04;

	// One result item
	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] address;
		logic [7:0]  value;
	} res_t;

	// Decode one hex digit: bit 4 flags a character that is not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] r;
		r = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b0, 4'(c - 8'h30)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b0, 4'(c - 8'h57)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b0, 4'(c - 8'h37)};
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/ihex_if.sv @@
// Valid/ready channel interfaces of the Intel HEX record parser: characters in, results out.
// No dependencies; the result kind is a plain three-bit field here.
interface ihex_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;

	modport source (output valid, output char_in, input ready);
	modport sink   (input valid, input char_in, output ready);
endinterface

interface ihex_rec_if;
	logic        valid;
	logic        ready;
	logic [2:0]  kind;
	logic [15:0] address;
	logic [7:0]  value;

	modport source (output valid, output kind, output address, output value, input ready);
	modport sink   (input valid, input kind, input address, input value, output ready);
endinterface

@@ hw/rtl/ihex_in_stage.sv @@
// Input register of the parser: holds one accepted character until the parser steps on it.
// Depends on ihex_char_if.
module ihex_in_stage (
	input  logic          clk,
	input  logic          arst_n,
	ihex_char_if.sink     chars,
	input  logic          take,
	output logic          valid_s1,
	output logic [7:0]    char_s1
);

	// Accept whenever the stage is empty or is consumed this cycle
	assign chars.ready = !valid_s1 || take;

	// Hold the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	// Capture the character on a transfer
	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.char_in;
		end
	end

endmodule

@@ hw/rtl/ihex_parse.sv @@
// Record decoder of the Intel HEX parser: phase state, pair assembly, checksum and addressing.
// Depends on ihex_pkg; steps once per character when the top level enables it.
module ihex_parse (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        char_s1,
	output logic              res_valid,
	output ihex_pkg::res_t    res
);

	localparam logic [3:0] PH_LINE_START = 4'd0;
	localparam logic [3:0] PH_SKIP       = 4'd1;
	localparam logic [3:0] PH_LEN        = 4'd2;
	localparam logic [3:0] PH_ADDR_HI    = 4'd3;
	localparam logic [3:0] PH_ADDR_LO    = 4'd4;
	localparam logic [3:0] PH_TYPE       = 4'd5;
	localparam logic [3:0] PH_DATA       = 4'd6;
	localparam logic [3:0] PH_CSUM       = 4'd7;
	localparam logic [3:0] PH_EXT_HI     = 4'd8;
	localparam logic [3:0] PH_EXT_LO     = 4'd9;
	localparam logic [3:0] PH_DONE       = 4'd10;
	localparam logic [3:0] PH_FAILED     = 4'd11;

	logic [3:0]  phase_q, phase_d;
	logic [3:0]  high_nibble_q, high_nibble_d;
	logic        pending_q, pending_d;
	logic [7:0]  rec_len_q, rec_len_d;
	logic [15:0] rec_addr_q, rec_addr_d;
	logic [7:0]  rec_type_q, rec_type_d;
	logic [7:0]  sum_q, sum_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  ext_high_q, ext_high_d;
	logic [15:0] base_low_q, base_low_d;

	logic [4:0]  digit;
	logic [7:0]  pair;
	logic [7:0]  pair_sum;
	logic [7:0]  count_inc;
	logic [15:0] target;

	assign digit     = ihex_pkg::hex_value(char_s1);
	assign pair      = {high_nibble_q, digit[3:0]};
	assign pair_sum  = sum_q + pair;
	assign count_inc = count_q + 8'd1;
	assign target    = base_low_q + rec_addr_q + {8'd0, count_q};

	// Work out the next state and the result for the character in the input register
	always_comb begin
		phase_d       = phase_q;
		high_nibble_d = high_nibble_q;
		pending_d     = pending_q;
		rec_len_d     = rec_len_q;
		rec_addr_d    = rec_addr_q;
		rec_type_d    = rec_type_q;
		sum_d         = sum_q;
		count_d       = count_q;
		ext_high_d    = ext_high_q;
		base_low_d    = base_low_q;
		res_valid     = 1'b0;
		res           = '0;

		unique case (phase_q)
			PH_DONE, PH_FAILED: begin
			end
			PH_LINE_START: begin
				if (char_s1 == ihex_pkg::CHAR_COLON) begin
					phase_d   = PH_LEN;
					pending_d = 1'b0;
					sum_d     = 8'd0;
				end else if (char_s1 != ihex_pkg::CHAR_LF) begin
					phase_d = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (char_s1 == ihex_pkg::CHAR_LF) begin
					phase_d = PH_LINE_START;
				end
			end
			PH_LEN, PH_ADDR_HI, PH_ADDR_LO, PH_TYPE, PH_DATA, PH_CSUM,
			PH_EXT_HI, PH_EXT_LO: begin
				if (digit[4]) begin
					// Not a hex digit: flag malformed and stop for good
					phase_d   = PH_FAILED;
					pending_d = 1'b0;
					res_valid = 1'b1;
					res.kind  = ihex_pkg::KIND_BAD;
				end else if (!pending_q) begin
					high_nibble_d = digit[3:0];
					pending_d     = 1'b1;
				end else begin
					// Second digit completes a pair
					pending_d = 1'b0;
					unique case (phase_q)
						PH_LEN: begin
							rec_len_d = pair;
							sum_d     = pair;
							phase_d   = PH_ADDR_HI;
						end
						PH_ADDR_HI: begin
							rec_addr_d = {pair, 8'd0};
							sum_d      = pair_sum;
							phase_d    = PH_ADDR_LO;
						end
						PH_ADDR_LO: begin
							rec_addr_d = {rec_addr_q[15:8], pair};
							sum_d      = pair_sum;
							phase_d    = PH_TYPE;
						end
						PH_TYPE: begin
							rec_type_d = pair;
							sum_d      = pair_sum;
							if (pair == ihex_pkg::REC_EOF) begin
								phase_d   = PH_DONE;
								res_valid = 1'b1;
								res.kind  = ihex_pkg::KIND_EOF;
							end else if (pair == ihex_pkg::REC_EXT_SEG ||
								pair == ihex_pkg::REC_EXT_LIN) begin
								phase_d = PH_EXT_HI;
							end else if (pair == ihex_pkg::REC_DATA) begin
								count_d = 8'd0;
								phase_d = (rec_len_q != 8'd0) ? PH_DATA : PH_CSUM;
							end else begin
								phase_d = PH_SKIP;
							end
						end
						PH_EXT_HI: begin
							ext_high_d = pair;
							phase_d    = PH_EXT_LO;
						end
						PH_EXT_LO: begin
							base_low_d = (rec_type_q == ihex_pkg::REC_EXT_LIN) ? 16'd0
								: {ext_high_q[3:0], pair, 4'd0};
							phase_d = PH_SKIP;
						end
						PH_DATA: begin
							sum_d       = pair_sum;
							count_d     = count_inc;
							if (count_inc == rec_len_q) begin
								phase_d = PH_CSUM;
							end
							res_valid   = 1'b1;
							res.kind    = ihex_pkg::KIND_DATA;
							res.address = target;
							res.value   = pair;
						end
						PH_CSUM: begin
							sum_d     = pair_sum;
							res_valid = 1'b1;
							if (pair_sum == 8'd0) begin
								phase_d  = PH_SKIP;
								res.kind = ihex_pkg::KIND_OK;
							end else begin
								phase_d  = PH_FAILED;
								res.kind = ihex_pkg::KIND_CSUM;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
				phase_d = PH_FAILED;
			end
		endcase
	end

	// Advance the state on each step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_LINE_START;
			high_nibble_q <= 4'd0;
			pending_q     <= 1'b0;
			rec_len_q     <= 8'd0;
			rec_addr_q    <= 16'd0;
			rec_type_q    <= 8'd0;
			sum_q         <= 8'd0;
			count_q       <= 8'd0;
			ext_high_q    <= 8'd0;
			base_low_q    <= 16'd0;
		end else if (step) begin
			phase_q       <= phase_d;
			high_nibble_q <= high_nibble_d;
			pending_q     <= pending_d;
			rec_len_q     <= rec_len_d;
			rec_addr_q    <= rec_addr_d;
			rec_type_q    <= rec_type_d;
			sum_q         <= sum_d;
			count_q       <= count_d;
			ext_high_q    <= ext_high_d;
			base_low_q    <= base_low_d;
		end
	end

endmodule

@@ hw/rtl/ihex_out_reg.sv @@
// Result register of the parser: holds one result until the receiver takes it.
// Depends on ihex_pkg and ihex_rec_if.
module ihex_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ihex_pkg::res_t    res,
	output logic              free,
	ihex_rec_if.source        records
);

	logic           valid_q;
	ihex_pkg::res_t res_q;

	// The register can take a new result when empty or drained this cycle
	assign free = !valid_q || records.ready;

	// Hold or refill the valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	// Capture the payload
	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign records.valid   = valid_q;
	assign records.kind    = res_q.kind;
	assign records.address = res_q.address;
	assign records.value   = res_q.value;

endmodule

@@ hw/rtl/intel_hex_record_parser.sv @@
// Intel HEX record parser, top level: input register, record decoder, result register.
// Depends on ihex_pkg, ihex_if, ihex_in_stage, ihex_parse and ihex_out_reg.
//
// Usage:
//   chars   - sink channel, one ASCII character of HEX text per transfer; line feed ends a line.
//   records - source channel, at most one result per character: a data byte with its
//             16-bit target address, record ok, end of file, checksum error or malformed.
//   Path: a taken character waits in the input register, and its result, if any, is
//   decoded into the result register.
//   Throughput: one character per cycle while no stall holds, set by the combinational decode
//   between the input register and the result register.
//   Stall: while the result register holds an untaken result, a character that makes
//   a new result waits in the input register; characters that make no result still
//   pass. chars.ready falls only when the input register is full and cannot step.
//   Reset: arst_n clears the valid flags of both registers and returns the decoder to
//   the start of a line with a zero base address. After end of file or an error every
//   further character is swallowed without a result until the next reset.
module intel_hex_record_parser (
	input  logic          clk,
	input  logic          arst_n,
	ihex_char_if.sink     chars,
	ihex_rec_if.source    records
);

	logic           valid_s1;
	logic [7:0]     char_s1;
	logic           step;
	logic           res_valid;
	ihex_pkg::res_t res;
	logic           out_free;

	// Step when a character waits and its result, if any, has room
	assign step = valid_s1 && (!res_valid || out_free);

	ihex_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars),
		.take     (step),
		.valid_s1 (valid_s1),
		.char_s1  (char_s1)
	);

	ihex_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.char_s1   (char_s1),
		.res_valid (res_valid),
		.res       (res)
	);

	ihex_out_reg u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (step && res_valid),
		.res     (res),
		.free    (out_free),
		.records (records)
	);

endmodule

@@ test/ihex_record_checker.sv @@
// Checker for the Intel HEX record parser: watches the character and result channels,
// predicts every result from the accepted characters and compares them field by field.
// Depends on ihex_pkg (kinds, characters, record types, res_t) and ihex_if (channels).
`timescale 1ns / 100ps
module ihex_record_checker (
	input  logic  clk,
	input  logic  arst_n,
	ihex_char_if  chars,
	ihex_rec_if   records,
	output int    failures,
	output int    pending
);

	localparam int REPORT_LIMIT = 10;

	typedef enum logic [3:0] {
		PH_LINE_START,
		PH_SKIP,
		PH_LEN,
		PH_ADDR_HI,
		PH_ADDR_LO,
		PH_TYPE,
		PH_DATA,
		PH_CSUM,
		PH_EXT_HI,
		PH_EXT_LO,
		PH_DONE,
		PH_FAILED
	} parse_phase_t;

	// Predicted parser state
	parse_phase_t phase;
	logic [3:0]   high_nib;
	logic         nib_pending;
	logic [7:0]   rec_len;
	logic [15:0]  rec_addr;
	logic [7:0]   rec_type;
	logic [7:0]   line_sum;
	logic [7:0]   byte_count;
	logic [7:0]   ext_high;
	logic [15:0]  base_addr;

	ihex_pkg::res_t expected_records[$];
	int             mismatches;

	task automatic expect_record(input logic [2:0] kind, input logic [15:0] addr,
			input logic [7:0] val);
		ihex_pkg::res_t r;
		r.kind = kind;
		r.address = addr;
		r.value = val;
		expected_records.push_back(r);
	endtask

	// Advance the predicted state by one character, queue any result it causes
	task automatic decode_char(input logic [7:0] c);
		logic [4:0] digit;
		logic [7:0] pair;
		logic [15:0] ext;
		// bit 4 marks a character that is not a hex digit
		digit = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) begin
			digit = 5'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			digit = 5'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			digit = 5'(c - 8'h37);
		end
		case (phase)
			PH_DONE, PH_FAILED: begin
			end
			PH_LINE_START: begin
				if (c == ihex_pkg::CHAR_COLON) begin
					phase = PH_LEN;
					nib_pending = 1'b0;
					line_sum = 8'h00;
				end else if (c != ihex_pkg::CHAR_LF) begin
					phase = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (c == ihex_pkg::CHAR_LF) begin
					phase = PH_LINE_START;
				end
			end
			default: begin
				if (digit[4]) begin
					phase = PH_FAILED;
					nib_pending = 1'b0;
					expect_record(ihex_pkg::KIND_BAD, 16'h0000, 8'h00);
				end else if (!nib_pending) begin
					high_nib = digit[3:0];
					nib_pending = 1'b1;
				end else begin
					nib_pending = 1'b0;
					pair = {high_nib, digit[3:0]};
					case (phase)
						PH_LEN: begin
							rec_len = pair;
							line_sum = pair;
							phase = PH_ADDR_HI;
						end
						PH_ADDR_HI: begin
							rec_addr = {pair, 8'h00};
							line_sum = line_sum + pair;
							phase = PH_ADDR_LO;
						end
						PH_ADDR_LO: begin
							rec_addr[7:0] = pair;
							line_sum = line_sum + pair;
							phase = PH_TYPE;
						end
						PH_TYPE: begin
							rec_type = pair;
							line_sum = line_sum + pair;
							if (pair == ihex_pkg::REC_EOF) begin
								phase = PH_DONE;
								expect_record(ihex_pkg::KIND_EOF, 16'h0000, 8'h00);
							end else if (pair == ihex_pkg::REC_EXT_SEG ||
									pair == ihex_pkg::REC_EXT_LIN) begin
								phase = PH_EXT_HI;
							end else if (pair == ihex_pkg::REC_DATA) begin
								byte_count = 8'h00;
								phase = (rec_len != 8'h00) ? PH_DATA : PH_CSUM;
							end else begin
								phase = PH_SKIP;
							end
						end
						PH_EXT_HI: begin
							ext_high = pair;
							phase = PH_EXT_LO;
						end
						PH_EXT_LO: begin
							// segment base is the value times 16, linear base clears it
							ext = {ext_high, pair};
							base_addr = (rec_type == ihex_pkg::REC_EXT_LIN) ? 16'h0000
								: {ext[11:0], 4'h0};
							phase = PH_SKIP;
						end
						PH_DATA: begin
							expect_record(ihex_pkg::KIND_DATA,
								base_addr + rec_addr + {8'h00, byte_count}, pair);
							line_sum = line_sum + pair;
							byte_count = byte_count + 8'h01;
							if (byte_count == rec_len) begin
								phase = PH_CSUM;
							end
						end
						PH_CSUM: begin
							line_sum = line_sum + pair;
							if (line_sum == 8'h00) begin
								phase = PH_SKIP;
								expect_record(ihex_pkg::KIND_OK, 16'h0000, 8'h00);
							end else begin
								phase = PH_FAILED;
								expect_record(ihex_pkg::KIND_CSUM, 16'h0000, 8'h00);
							end
						end
						default: begin
						end
					endcase
				end
			end
		endcase
	endtask

	// Predict on each character transfer, compare on each result transfer
	always @(posedge clk or negedge arst_n) begin : watch_channels
		ihex_pkg::res_t got;
		ihex_pkg::res_t want;
		if (!arst_n) begin
			phase = PH_LINE_START;
			high_nib = 4'h0;
			nib_pending = 1'b0;
			rec_len = 8'h00;
			rec_addr = 16'h0000;
			rec_type = 8'h00;
			line_sum = 8'h00;
			byte_count = 8'h00;
			ext_high = 8'h00;
			base_addr = 16'h0000;
			expected_records.delete();
			mismatches = 0;
		end else begin
			if (chars.valid && chars.ready) begin
				decode_char(chars.char_in);
			end
			if (records.valid && records.ready) begin
				got.kind = records.kind;
				got.address = records.address;
				got.value = records.value;
				if (expected_records.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT) begin
						$display("unexpected result: kind %0d address %h value %h",
							got.kind, got.address, got.value);
					end
				end else begin
					want = expected_records.pop_front();
					if (got.kind !== want.kind || got.address !== want.address ||
							got.value !== want.value) begin
						mismatches++;
						if (mismatches <= REPORT_LIMIT) begin
							$display("result mismatch: expected kind %0d address %h value %h,",
								want.kind, want.address, want.value,
								" got kind %0d address %h value %h",
								got.kind, got.address, got.value);
						end
					end
				end
			end
		end
		failures <= mismatches;
		pending <= expected_records.size();
	end

endmodule

@@ test/testbench.sv @@
// Top of the Intel HEX record parser testbench: clock, reset, character stimulus, result stalls
// and the verdict. Depends on ihex_pkg, ihex_if, the parser RTL and ihex_record_checker.
`timescale 1ns / 100ps
module testbench;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int STREAM_CHARS = 1200;
	localparam int DRAIN_CYCLES = 10;
	localparam logic [7:0] CHAR_CR = 8'h0D;

	typedef enum {MIXED_CASE, LOWER_CASE, UPPER_CASE} digit_case_t;
	typedef enum {END_EOF, END_BAD_SUM, END_MALFORMED} stream_end_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int failures;
	int pending;
	int cycles = 0;
	int unsigned record_chars = 0;
	int unsigned tx_calm = 0;
	int unsigned rx_calm = 0;
	int unsigned rx_stall = 0;

	// Line under construction and the data bytes of the next data record
	logic [7:0] line_chars[$];
	logic [7:0] rec_data[$];
	logic [7:0] line_sum;

	ihex_char_if chars_if ();
	ihex_rec_if  records_if ();

	intel_hex_record_parser dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_if),
		.records (records_if)
	);

	ihex_record_checker watch (
		.clk      (clk),
		.arst_n   (arst_n),
		.chars    (chars_if),
		.records  (records_if),
		.failures (failures),
		.pending  (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, a few long ones, now and then a calm stretch with none
	function automatic int unsigned pick_gap(inout int unsigned calm);
		int unsigned r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [7:0] hex_digit(input logic [3:0] n, input bit upper);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return upper ? 8'h37 + 8'(n) : 8'h57 + 8'(n);
	endfunction

	function automatic logic [7:0] text_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (c == ihex_pkg::CHAR_LF);
		return c;
	endfunction

	function automatic void put_pair(input logic [7:0] b, input digit_case_t dc);
		bit upper;
		upper = (dc == UPPER_CASE) || (dc == MIXED_CASE && $urandom_range(0, 1) == 1);
		line_chars.push_back(hex_digit(b[7:4], upper));
		upper = (dc == UPPER_CASE) || (dc == MIXED_CASE && $urandom_range(0, 1) == 1);
		line_chars.push_back(hex_digit(b[3:0], upper));
		line_sum = line_sum + b;
	endfunction

	function automatic void start_record();
		line_chars.delete();
		line_sum = 8'h00;
		line_chars.push_back(ihex_pkg::CHAR_COLON);
	endfunction

	// Close a line: bare line feed, carriage return first, or some junk that is skipped
	function automatic void put_line_end();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r >= 8) begin
			repeat ($urandom_range(1, 6)) line_chars.push_back(text_byte());
		end else if (r >= 5) begin
			line_chars.push_back(CHAR_CR);
		end
		line_chars.push_back(ihex_pkg::CHAR_LF);
	endfunction

	function automatic void fill_data(input int unsigned len);
		rec_data.delete();
		repeat (len) rec_data.push_back(8'($urandom_range(0, 255)));
	endfunction

	function automatic void build_data_record(input logic [15:0] addr, input bit bad_sum,
			input digit_case_t dc);
		logic [7:0] csum;
		start_record();
		put_pair(8'(rec_data.size()), dc);
		put_pair(addr[15:8], dc);
		put_pair(addr[7:0], dc);
		put_pair(ihex_pkg::REC_DATA, dc);
		foreach (rec_data[i]) put_pair(rec_data[i], dc);
		csum = 8'h00 - line_sum;
		if (bad_sum) csum = csum ^ 8'($urandom_range(1, 255));
		put_pair(csum, dc);
		put_line_end();
	endfunction

	// Base records: the checksum pair is never read, so it is random
	function automatic void build_base_record(input logic [7:0] rtype, input logic [15:0] v,
			input digit_case_t dc);
		start_record();
		put_pair(8'h02, dc);
		put_pair(8'h00, dc);
		put_pair(8'h00, dc);
		put_pair(rtype, dc);
		put_pair(v[15:8], dc);
		put_pair(v[7:0], dc);
		put_pair(8'($urandom_range(0, 255)), dc);
		put_line_end();
	endfunction

	function automatic void build_skipped_record(input logic [7:0] rtype);
		start_record();
		put_pair(8'($urandom_range(0, 255)), MIXED_CASE);
		put_pair(8'($urandom_range(0, 255)), MIXED_CASE);
		put_pair(8'($urandom_range(0, 255)), MIXED_CASE);
		put_pair(rtype, MIXED_CASE);
		repeat ($urandom_range(0, 12)) line_chars.push_back(text_byte());
		line_chars.push_back(ihex_pkg::CHAR_LF);
	endfunction

	function automatic void build_noise_line();
		logic [7:0] c;
		line_chars.delete();
		do c = text_byte(); while (c == ihex_pkg::CHAR_COLON);
		line_chars.push_back(c);
		repeat ($urandom_range(0, 15)) line_chars.push_back(text_byte());
		line_chars.push_back(ihex_pkg::CHAR_LF);
	endfunction

	function automatic void build_eof_record();
		start_record();
		put_pair(8'h00, MIXED_CASE);
		put_pair(8'h00, MIXED_CASE);
		put_pair(8'h00, MIXED_CASE);
		put_pair(ihex_pkg::REC_EOF, MIXED_CASE);
		put_pair(8'($urandom_range(0, 255)), MIXED_CASE);
		put_line_end();
	endfunction

	// One character transfer, after a random gap with valid low
	task automatic send_char(input logic [7:0] c);
		int unsigned gap;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			chars_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_if.valid <= 1'b1;
		chars_if.char_in <= c;
		do @(posedge clk); while (!chars_if.ready);
	endtask

	task automatic send_line();
		if (line_chars.size() > 0 && line_chars[0] == ihex_pkg::CHAR_COLON) begin
			record_chars += line_chars.size();
		end
		foreach (line_chars[i]) send_char(line_chars[i]);
		line_chars.delete();
	endtask

	// Hold the sender until every predicted result has been taken
	task automatic drain_results();
		chars_if.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Stall the result channel at random
	initial begin
		records_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_stall > 0) begin
				records_if.ready <= 1'b0;
				rx_stall--;
			end else begin
				records_if.ready <= 1'b1;
				rx_stall = pick_gap(rx_calm);
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned r;
		int unsigned k;
		logic [7:0] rtype;
		logic [7:0] bad_char;
		bit long_done;
		stream_end_t ending;
		chars_if.valid <= 1'b0;
		chars_if.char_in <= 8'h00;
		long_done = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Empty line, then a skipped line of odd bytes with a colon inside
		line_chars.delete();
		line_chars.push_back(ihex_pkg::CHAR_LF);
		send_line();
		line_chars = '{8'h00, 8'hFF, ihex_pkg::CHAR_COLON, 8'h7F, 8'h80, ihex_pkg::CHAR_LF};
		send_line();

		// Every hex digit in both cases; upper case record wraps past 0xFFFF
		rec_data = '{8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF};
		build_data_record(16'h0000, 1'b0, LOWER_CASE);
		send_line();
		build_data_record(16'hFFFF, 1'b0, UPPER_CASE);
		send_line();
		rec_data = '{8'h00, 8'hFF};
		build_data_record(16'h1234, 1'b0, MIXED_CASE);
		send_line();

		// Zero-length data record: checksum straight after the type
		rec_data.delete();
		build_data_record(16'hFFFF, 1'b0, MIXED_CASE);
		send_line();

		// Segment base at its maximum, data wraps around the top of the space
		build_base_record(ihex_pkg::REC_EXT_SEG, 16'hFFFF, UPPER_CASE);
		send_line();
		fill_data(16);
		build_data_record(16'h0008, 1'b0, MIXED_CASE);
		send_line();

		// Segment base shifted out of 16 bits, then an ordinary one
		build_base_record(ihex_pkg::REC_EXT_SEG, 16'h1000, LOWER_CASE);
		send_line();
		fill_data(1);
		build_data_record(16'h0100, 1'b0, MIXED_CASE);
		send_line();
		build_base_record(ihex_pkg::REC_EXT_SEG, 16'h0123, MIXED_CASE);
		send_line();
		fill_data(2);
		build_data_record(16'h0004, 1'b0, MIXED_CASE);
		send_line();

		// Linear base clears the low base
		build_base_record(ihex_pkg::REC_EXT_LIN, 16'hFFFF, MIXED_CASE);
		send_line();
		fill_data(2);
		build_data_record(16'h4000, 1'b0, MIXED_CASE);
		send_line();

		// Unknown types are skipped to the line feed
		build_skipped_record(8'h03);
		send_line();
		build_skipped_record(8'hFF);
		send_line();

		drain_results();

		// Random stream: mostly well-formed records, some noise and empty lines
		while (record_chars < STREAM_CHARS) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				if (!long_done && record_chars > STREAM_CHARS / 2) begin
					long_done = 1'b1;
					fill_data(255);
				end else if ($urandom_range(0, 6) == 0) begin
					fill_data($urandom_range(17, 40));
				end else begin
					fill_data($urandom_range(0, 16));
				end
				build_data_record(16'($urandom), 1'b0, MIXED_CASE);
			end else if (r < 68) begin
				build_base_record(ihex_pkg::REC_EXT_SEG, 16'($urandom), MIXED_CASE);
			end else if (r < 72) begin
				build_base_record(ihex_pkg::REC_EXT_LIN, 16'($urandom), MIXED_CASE);
			end else if (r < 80) begin
				do rtype = 8'($urandom_range(0, 255));
				while (rtype == ihex_pkg::REC_DATA || rtype == ihex_pkg::REC_EOF ||
					rtype == ihex_pkg::REC_EXT_SEG || rtype == ihex_pkg::REC_EXT_LIN);
				build_skipped_record(rtype);
			end else if (r < 90) begin
				build_noise_line();
			end else begin
				line_chars.delete();
				line_chars.push_back(ihex_pkg::CHAR_LF);
			end
			send_line();
		end

		// End the stream one of the three sticky ways
		ending = stream_end_t'($urandom_range(0, 2));
		case (ending)
			END_EOF: begin
				build_eof_record();
				send_line();
			end
			END_BAD_SUM: begin
				fill_data($urandom_range(0, 8));
				build_data_record(16'($urandom), 1'b1, MIXED_CASE);
				send_line();
			end
			default: begin
				// cut a record at any digit, mid pair included, with a non-hex character
				fill_data($urandom_range(0, 4));
				build_data_record(16'($urandom), 1'b0, MIXED_CASE);
				k = $urandom_range(0, 9 + 2 * rec_data.size());
				case ($urandom_range(0, 11))
					0: bad_char = ihex_pkg::CHAR_LF;
					1: bad_char = CHAR_CR;
					2: bad_char = 8'h20;
					3: bad_char = 8'h2B;
					4: bad_char = 8'h2D;
					5: bad_char = 8'h2F;
					6: bad_char = ihex_pkg::CHAR_COLON;
					7: bad_char = 8'h40;
					8: bad_char = 8'h47;
					9: bad_char = 8'h60;
					10: bad_char = 8'h67;
					default: bad_char = 8'($urandom_range(128, 255));
				endcase
				for (int i = 0; i <= k; i++) send_char(line_chars[i]);
				send_char(bad_char);
				line_chars.delete();
			end
		endcase

		// Everything after the sticky end is swallowed
		fill_data(3);
		build_data_record(16'($urandom), 1'b0, MIXED_CASE);
		send_line();
		build_noise_line();
		send_line();
		build_eof_record();
		send_line();

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && pending == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

@@ intel_hex_record_parser.f @@
hw/rtl/ihex_pkg.sv
hw/rtl/ihex_if.sv
hw/rtl/ihex_in_stage.sv
hw/rtl/ihex_parse.sv
hw/rtl/ihex_out_reg.sv
hw/rtl/intel_hex_record_parser.sv
test/ihex_record_checker.sv
test/testbench.sv
